// ===== rtl/masrr_pkg.sv =====
// Package for the multi-axis step-rate ramp: axis record layout, prescaler
// codes, item kinds and the prescaler shift table. No dependencies.
`timescale 1ns / 1ps

package masrr_pkg;

    localparam int RATE_W = 33;
    localparam int STEP_W = 32;
    localparam int PRE_W  = 3;
    localparam int FREQ_W = 17;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [PRE_W-1:0] PRE_OFF     = 3'd0;
    localparam logic [PRE_W-1:0] PRE_DIV1    = 3'd1;
    localparam logic [PRE_W-1:0] PRE_DIV8    = 3'd2;
    localparam logic [PRE_W-1:0] PRE_DIV64   = 3'd3;
    localparam logic [PRE_W-1:0] PRE_DIV256  = 3'd4;
    localparam logic [PRE_W-1:0] PRE_DIV1024 = 3'd5;
    localparam logic [PRE_W-1:0] PRE_MASK    = 3'b111;

    typedef struct packed {
        logic                     ramping;
        logic [STEP_W-1:0]        step;
        logic signed [RATE_W-1:0] target;
        logic signed [RATE_W-1:0] rate;
    } axis_entry_t;

    // right shift taken when moving up from prescaler code sel
    function automatic logic [2:0] pre_shift(input logic [PRE_W-1:0] sel);
        logic [2:0] sh;
        unique case (sel & PRE_MASK)
            PRE_OFF:     sh = 3'd1;
            PRE_DIV1:    sh = 3'd3;
            PRE_DIV8:    sh = 3'd3;
            PRE_DIV64:   sh = 3'd2;
            PRE_DIV256:  sh = 3'd2;
            default:     sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage

// ===== rtl/masrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module masrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== rtl/multi_axis_step_rate_ramp_top.sv =====
// Top level of the multi-axis step-rate ramp generator.
// Depends on masrr_pkg and masrr_ram.
`timescale 1ns / 1ps

// One word is handled at a time. A load word goes from acceptance through the
// prepare, divide, prescaler and finish states, a tick word first through the
// two update states. The one-bit-per-cycle divider forms CLOCK_HZ / f over
// the bit width of CLOCK_HZ (24 at the default), then the prescaler walk;
// a zero integer rate skips both. Axis records live in a small RAM with one
// valid flag per axis that reset clears, so no clearing pass is needed.
// The half-period mask is sampled while a word is processed, so write it
// only while no word is in flight.
module multi_axis_step_rate_ramp_top
    import masrr_pkg::*;
#(
    parameter int AXES        = 4,
    parameter int CLOCK_HZ    = 16000000,
    parameter int PERIOD_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // axis[1:0], start_rate[34:2], target_rate[67:35], ramp_step[99:68],
    // ramp_enable[100], hold_mask[104:101], zero fill
    input  logic [111:0] s_tdata,
    // func
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_axis[1:0], prescale_select[4:2], compare_period[20:5],
    // half_compare[36:21], current_rate[69:37], still_ramping[70],
    // all_reached[71]
    output logic [71:0]  m_tdata,
    // sweep_end
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data
);

    localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int CW = $clog2(CLOCK_HZ + 1);
    localparam int KW = $clog2(CW);
    localparam logic [CW-1:0] DIVIDEND = CW'(CLOCK_HZ);
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_UPD1  = 7'b0000010,
        ST_UPD2  = 7'b0000100,
        ST_PREP  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_PRESC = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic                     in_func;
    logic [1:0]               in_axis;
    logic signed [RATE_W-1:0] in_start;
    logic signed [RATE_W-1:0] in_target;
    logic [STEP_W-1:0]        in_step;
    logic                     in_en;
    logic [3:0]               in_hold;

    assign in_func   = s_tuser;
    assign in_axis   = s_tdata[1:0];
    assign in_start  = s_tdata[34:2];
    assign in_target = s_tdata[67:35];
    assign in_step   = s_tdata[99:68];
    assign in_en     = s_tdata[100];
    assign in_hold   = s_tdata[104:101];

    logic s_acc;
    logic in_ok;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_ok    = (32'(in_axis) < 32'(AXES));
    assign cfg_ready = 1'b1;

    // control state
    logic [3:0]      mask_reg;
    logic [AXES-1:0] vld_reg;
    logic [IW-1:0]   serve_reg;
    logic            done_reg;
    logic            out_valid_reg;

    // working registers
    logic [3:0]                hold_reg;
    logic                      rd_vld_reg;
    logic [1:0]                axis_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic signed [RATE_W-1:0]  tgt_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      ent_ramp_reg;
    logic                      ramp_reg;
    logic                      s_zero_reg;
    logic                      s_pos_reg;
    logic signed [RATE_W+1:0]  f1_reg;
    logic                      se_reg;
    logic                      sweep_reg;
    logic                      all_reg;
    logic [FREQ_W-1:0]         freq_reg;
    logic [FREQ_W-1:0]         rem_reg;
    logic [CW-1:0]             p_reg;
    logic [KW-1:0]             cnt_reg;
    logic [PRE_W-1:0]          sel_reg;

    // output registers
    logic [71:0] out_data_reg;
    logic        out_last_reg;

    // RAM
    axis_entry_t ram_wdata, ram_rdata, ent;
    logic        ram_we;
    logic [IW-1:0] ram_waddr;
    logic        ram_re;

    masrr_ram #(
        .WIDTH ($bits(axis_entry_t)),
        .DEPTH (AXES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (serve_reg),
        .rdata (ram_rdata)
    );

    assign ram_re = s_acc && (in_func == FUNC_TICK);
    assign ent    = rd_vld_reg ? ram_rdata : '0;

    // first update cycle: direction and stepped rate
    logic signed [RATE_W+1:0] rate_x, tgt_x, step_x;
    logic                     held, s_gt, s_eq;
    logic [1:0]               serve_lo;
    logic                     serve_small;

    assign serve_lo    = 2'(serve_reg);
    assign serve_small = (32'(serve_reg) < 32'd4);
    assign held        = serve_small && hold_reg[serve_lo];
    assign rate_x      = {{2{ent.rate[RATE_W-1]}}, ent.rate};
    assign tgt_x       = {{2{ent.target[RATE_W-1]}}, ent.target};
    assign step_x      = {3'b000, ent.step};
    assign s_gt        = (tgt_x > rate_x);
    assign s_eq        = (tgt_x == rate_x);

    // second update cycle: overshoot check and write-back
    logic signed [RATE_W+1:0] tgt_r_x;
    logic                     reached, keep_ramp, last, done_new;
    logic signed [RATE_W-1:0] rate_new;

    assign tgt_r_x   = {{2{tgt_reg[RATE_W-1]}}, tgt_reg};
    assign reached   = s_zero_reg || (s_pos_reg ? !(tgt_r_x > f1_reg) : !(tgt_r_x < f1_reg));
    assign keep_ramp = ent_ramp_reg && !reached;
    assign rate_new  = ent_ramp_reg ? (reached ? tgt_reg : f1_reg[RATE_W-1:0]) : rate_reg;
    assign last      = ((32'(serve_reg) + 32'd1) >= 32'(AXES));
    assign done_new  = done_reg && !keep_ramp;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = serve_reg;
        ram_wdata = '{ramping: keep_ramp, step: step_reg, target: tgt_reg, rate: rate_new};
        if (s_acc && (in_func == FUNC_LOAD) && in_ok) begin
            ram_we    = 1'b1;
            ram_waddr = IW'(in_axis);
            ram_wdata = '{ramping: in_en, step: in_step, target: in_target, rate: in_start};
        end else if ((state_reg == ST_UPD2) && ent_ramp_reg) begin
            ram_we = 1'b1;
        end
    end

    // magnitude of the integer rate
    logic [RATE_W:0]   mag;
    logic [FREQ_W-1:0] freq;
    assign mag  = rate_reg[RATE_W-1] ? ((RATE_W+1)'(0) - {rate_reg[RATE_W-1], rate_reg})
                                     : {rate_reg[RATE_W-1], rate_reg};
    assign freq = mag[RATE_W-1:16];

    // divider step
    logic [FREQ_W:0] trial;
    logic            q_bit;
    assign trial = {rem_reg, DIVIDEND[cnt_reg]};
    assign q_bit = (trial >= {1'b0, freq_reg});

    // prescaler step
    logic [2:0]    sh;
    logic [CW-1:0] p_half;
    logic          p_big;
    logic          presc_go;
    assign sh       = pre_shift(sel_reg);
    assign p_half   = p_reg >> (sh - 3'd1);
    assign p_big    = ((p_reg >> PERIOD_BITS) != '0);
    assign presc_go = p_big && (sh != 3'd0);

    // final values
    logic [15:0] per;
    logic [15:0] half;
    logic        out_free;
    assign per      = p_big ? 16'(PERIOD_MAX) : 16'(p_reg[PERIOD_BITS-1:0]);
    assign half     = se_reg ? {1'b0, per[15:1]} : 16'd0;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = (in_func == FUNC_TICK) ? ST_UPD1 : ST_PREP;
                end
            end
            ST_UPD1:  state_next = ST_UPD2;
            ST_UPD2:  state_next = ST_PREP;
            ST_PREP:  state_next = (freq == '0) ? ST_FIN : ST_DIV;
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_PRESC;
                end
            end
            ST_PRESC: begin
                if (!presc_go) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            vld_reg       <= '0;
            serve_reg     <= '0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                mask_reg <= cfg_data;
            end
            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (state_reg == ST_UPD2) begin
                if (last) begin
                    serve_reg <= '0;
                    done_reg  <= 1'b1;
                end else begin
                    serve_reg <= serve_reg + 1'b1;
                    done_reg  <= done_new;
                end
            end
            if ((state_reg == ST_FIN) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    hold_reg   <= in_hold;
                    rd_vld_reg <= vld_reg[serve_reg];
                    sweep_reg  <= 1'b0;
                    all_reg    <= 1'b0;
                    if (in_func == FUNC_LOAD) begin
                        axis_reg <= in_axis;
                        rate_reg <= in_ok ? in_start : '0;
                        ramp_reg <= in_ok && in_en;
                        se_reg   <= in_ok && mask_reg[in_axis];
                    end else begin
                        axis_reg <= serve_lo;
                    end
                end
            end
            ST_UPD1: begin
                rate_reg     <= ent.rate;
                tgt_reg      <= ent.target;
                step_reg     <= ent.step;
                ent_ramp_reg <= ent.ramping;
                s_zero_reg   <= s_eq;
                s_pos_reg    <= s_gt;
                if (held || s_eq) begin
                    f1_reg <= rate_x;
                end else if (s_gt) begin
                    f1_reg <= rate_x + step_x;
                end else begin
                    f1_reg <= rate_x - step_x;
                end
            end
            ST_UPD2: begin
                rate_reg  <= rate_new;
                ramp_reg  <= keep_ramp;
                se_reg    <= serve_small && mask_reg[serve_lo];
                sweep_reg <= last;
                all_reg   <= last && done_new;
            end
            ST_PREP: begin
                freq_reg <= freq;
                rem_reg  <= '0;
                p_reg    <= '0;
                cnt_reg  <= KW'(CW - 1);
                sel_reg  <= (freq == '0) ? PRE_OFF : PRE_DIV1;
            end
            ST_DIV: begin
                rem_reg <= q_bit ? FREQ_W'(trial - {1'b0, freq_reg}) : FREQ_W'(trial);
                p_reg   <= {p_reg[CW-2:0], q_bit};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_PRESC: begin
                if (presc_go) begin
                    p_reg   <= (p_half >> 1) + CW'(p_half[0]);
                    sel_reg <= sel_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_data_reg <= {all_reg, ramp_reg, rate_reg, half, per, sel_reg, axis_reg};
                    out_last_reg <= sweep_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_ram_write_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE) || (state_reg == ST_UPD2))
        else $error("axis RAM written outside load or write-back");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (freq_reg != '0))
        else $error("divider running on zero rate");

    a_sweep_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_UPD2) && last) |=> (serve_reg == '0) && done_reg)
        else $error("round-robin index did not wrap at sweep end");

    a_sel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (sel_reg <= PRE_DIV1024)
                                  && ((sel_reg != PRE_OFF) || (p_reg == '0)))
        else $error("prescaler code out of range or off with non-zero period");
`endif

endmodule
